// ===== sv/nlmc_pkg.sv =====
package nlmc_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned SecW = 8;
  localparam int unsigned TickW = 8;
  localparam int unsigned LightW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [LevelW-1:0] LevelFull = 8'hff;
  localparam logic [SecW-1:0] SecondsBeyond = 8'hff;

  localparam logic [SecW-1:0] TiltOnReset = 8'd60;
  localparam logic [SecW-1:0] DarkOnReset = 8'd15;
  localparam logic [TickW-1:0] TicksReset = 8'd122;
  localparam logic [LightW-1:0] SamplesReset = 4'd10;
  localparam logic [SecW-1:0] RearmReset = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TILT_ON = 3'd0,
    REG_DARK_ON = 3'd1,
    REG_TICKS   = 3'd2,
    REG_SAMPLES = 3'd3,
    REG_REARM   = 3'd4
  } nlmc_reg_e;

  typedef enum logic [1:0] {
    CMD_SUB_TICK = 2'd0,
    CMD_RAMP     = 2'd1,
    CMD_WAKE     = 2'd2,
    CMD_TILT     = 2'd3
  } nlmc_cmd_e;

  typedef enum logic [1:0] {
    MODE_ASLEEP = 2'd0,
    MODE_UP     = 2'd1,
    MODE_DOWN   = 2'd2
  } nlmc_mode_e;

  typedef struct packed {
    logic [SecW-1:0]   tilt_on_seconds;
    logic [SecW-1:0]   dark_on_seconds;
    logic [TickW-1:0]  ticks_per_second;
    logic [LightW-1:0] light_samples_needed;
    logic [SecW-1:0]   rearm_seconds;
  } nlmc_cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] pwm_level;
    logic              led_drive_on;
    logic              awake;
    logic              tilt_armed;
  } nlmc_result_t;

endpackage

// ===== sv/nlmc_cfg.sv =====
module nlmc_cfg
  import nlmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output nlmc_cfg_t           cfg_o
);

  nlmc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tilt_on_seconds      <= TiltOnReset;
      cfg_q.dark_on_seconds      <= DarkOnReset;
      cfg_q.ticks_per_second     <= TicksReset;
      cfg_q.light_samples_needed <= SamplesReset;
      cfg_q.rearm_seconds        <= RearmReset;
    end else if (cfg_valid_i) begin
      case (nlmc_reg_e'(cfg_index_i))
        REG_TILT_ON: cfg_q.tilt_on_seconds <= cfg_data_i;
        REG_DARK_ON: cfg_q.dark_on_seconds <= cfg_data_i;
        REG_TICKS:   cfg_q.ticks_per_second <= cfg_data_i;
        REG_SAMPLES: cfg_q.light_samples_needed <= cfg_data_i[LightW-1:0];
        REG_REARM:   cfg_q.rearm_seconds <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/nlmc_core.sv =====
module nlmc_core
  import nlmc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  nlmc_cfg_t    cfg_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   cmd_i,
  input  logic         light_seen_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output nlmc_result_t res_o
);

  logic             stage_valid_q;
  nlmc_cmd_e        stage_cmd_q;
  logic             stage_light_q;
  logic             fire;

  logic [LevelW-1:0] level_q, level_d;
  nlmc_mode_e        mode_q, mode_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic [TickW-1:0]  sub_q, sub_d;
  logic [LightW-1:0] lcount_q, lcount_d;
  logic              armed_q, armed_d;
  logic              dark_fire;
  logic              holding;

  assign fire       = stage_valid_q && res_ready_i;
  assign in_ready_o = !stage_valid_q || res_ready_i;

  always_comb begin
    level_d   = level_q;
    mode_d    = mode_q;
    sec_d     = sec_q;
    sub_d     = sub_q;
    lcount_d  = lcount_q;
    armed_d   = armed_q;
    dark_fire = 1'b0;
    case (stage_cmd_q)
      CMD_SUB_TICK: begin
        if (mode_q != MODE_ASLEEP) begin
          sub_d = sub_q + 8'd1;
          if (sub_d > cfg_i.ticks_per_second) begin
            sub_d = '0;
            if (sec_q != SecondsBeyond) begin
              sec_d = sec_q + 8'd1;
            end
          end
        end
      end
      CMD_RAMP: begin
        case (mode_q)
          MODE_UP: begin
            if (level_q != LevelFull) begin
              level_d = level_q + 8'd1;
            end
          end
          MODE_DOWN: begin
            if (level_q != '0) begin
              level_d = level_q - 8'd1;
            end
            if (level_d == '0) begin
              mode_d  = MODE_ASLEEP;
              sec_d   = '0;
              armed_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      CMD_WAKE: begin
        if (level_q == '0) begin
          sec_d = SecondsBeyond;
          if (stage_light_q) begin
            if (lcount_q < cfg_i.light_samples_needed) begin
              lcount_d = lcount_q + 4'd1;
            end
          end else if (lcount_q >= cfg_i.light_samples_needed) begin
            lcount_d  = '0;
            sec_d     = (cfg_i.tilt_on_seconds > cfg_i.dark_on_seconds) ?
                        cfg_i.tilt_on_seconds - cfg_i.dark_on_seconds : '0;
            armed_d   = 1'b1;
            dark_fire = 1'b1;
          end
          if (mode_q == MODE_ASLEEP) begin
            if (dark_fire) begin
              mode_d = MODE_UP;
            end else begin
              sec_d   = '0;
              armed_d = 1'b1;
            end
          end
        end
      end
      CMD_TILT: begin
        if (armed_q) begin
          armed_d = 1'b0;
          sec_d   = '0;
          if (mode_q == MODE_ASLEEP) begin
            mode_d = MODE_UP;
          end
        end
      end
      default: ;
    endcase
    holding = (mode_d == MODE_UP) && (level_d == LevelFull);
    if (holding) begin
      if (sec_d > cfg_i.rearm_seconds) begin
        armed_d = 1'b1;
      end
      if (sec_d > cfg_i.tilt_on_seconds) begin
        mode_d = MODE_DOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      level_q       <= '0;
      mode_q        <= MODE_ASLEEP;
      sec_q         <= '0;
      sub_q         <= '0;
      lcount_q      <= SamplesReset;
      armed_q       <= 1'b1;
    end else begin
      if (in_ready_o) begin
        stage_valid_q <= in_valid_i;
      end
      if (fire) begin
        level_q  <= level_d;
        mode_q   <= mode_d;
        sec_q    <= sec_d;
        sub_q    <= sub_d;
        lcount_q <= lcount_d;
        armed_q  <= armed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_cmd_q   <= nlmc_cmd_e'(cmd_i);
      stage_light_q <= light_seen_i;
    end
  end

  assign res_valid_o        = stage_valid_q;
  assign res_o.pwm_level    = level_d;
  assign res_o.led_drive_on = (mode_d != MODE_ASLEEP);
  assign res_o.awake        = (mode_d != MODE_ASLEEP);
  assign res_o.tilt_armed   = armed_d;

endmodule

// ===== sv/nlmc_out.sv =====
module nlmc_out
  import nlmc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         res_valid_i,
  output logic         res_ready_o,
  input  nlmc_result_t res_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output nlmc_result_t out_o
);

  logic         out_valid_q;
  nlmc_result_t out_q;

  assign res_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== sv/night_light_mode_controller.sv =====
// Event-driven night-light lamp controller. Each input beat carries one event
// (sub-tick, ramp step, watchdog wake with the light bit, or tilt edge) and
// yields exactly one output beat with the PWM level, LED drive, awake and
// tilt-armed flags as they stand after that event. One event is accepted per
// clock cycle while the output is not stalled; an event passes an input stage
// and then a result register before its result is presented on the output.
// Configuration registers are to be written through the cfg port only while
// idle, which the block does not enforce; the port is always ready.
module night_light_mode_controller
  import nlmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic                light_seen_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LevelW-1:0]   pwm_level_o,
  output logic                led_drive_on_o,
  output logic                awake_o,
  output logic                tilt_armed_o
);

  nlmc_cfg_t    cfg;
  nlmc_result_t res;
  nlmc_result_t out;
  logic         res_valid;
  logic         res_ready;

  assign cfg_ready_o = 1'b1;

  nlmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  nlmc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .light_seen_i (light_seen_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  nlmc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  assign pwm_level_o    = out.pwm_level;
  assign led_drive_on_o = out.led_drive_on;
  assign awake_o        = out.awake;
  assign tilt_armed_o   = out.tilt_armed;

endmodule

// ===== sv/nlmc_checker.sv =====
module nlmc_checker
  import nlmc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [LevelW-1:0] pwm_level_o,
  input logic              led_drive_on_o,
  input logic              awake_o,
  input logic              tilt_armed_o
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pwm_level_o) &&
      $stable(awake_o) && $stable(tilt_armed_o))
    else $error("output beat changed while stalled");

  // The LED is driven exactly when the lamp is awake.
  a_drive_awake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> led_drive_on_o == awake_o)
    else $error("LED drive differs from awake flag");

  // A sleeping lamp is dark and ready for a tilt.
  a_sleep_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !awake_o |-> pwm_level_o == '0 && tilt_armed_o)
    else $error("sleeping lamp not dark or not armed");

  // With the result register empty the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind night_light_mode_controller nlmc_checker u_nlmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pwm_level_o    (pwm_level_o),
  .led_drive_on_o (led_drive_on_o),
  .awake_o        (awake_o),
  .tilt_armed_o   (tilt_armed_o)
);
